// ----- hw/rtl/cfr_pkg.sv -----
`timescale 1ns / 1ps

package cfr_pkg;

   // Internal significand: hidden bit, 23 fraction bits, then guard and two extra bits.
   localparam int SIG_W = 27;
   localparam int SH_W = $clog2(SIG_W);
   // Signed biased exponent, wide enough for every intermediate range.
   localparam int EXP_W = 11;
   // Quotient bits resolved in each divider stage.
   localparam int DIV_RADIX_BITS = 3;
   localparam int DIV_ITER_STAGES = SIG_W / DIV_RADIX_BITS;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF = 32'h7F80_0000;
   localparam logic [31:0] POS_ZERO = 32'h0000_0000;
   localparam logic [7:0] EXP_MAX = 8'hFF;

   typedef struct packed {
      logic [31:0] in_re;
      logic [31:0] in_im;
      logic in_last;
   } req_type;

   typedef struct packed {
      logic [31:0] out_re;
      logic [31:0] out_im;
      logic out_last;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_FINITE,
      CLS_INF,
      CLS_NAN
   } fclass_type;

   typedef struct packed {
      logic [23:0] sig;
      logic [7:0] eff;
   } upk_type;

   // Unrounded value: sig * 2^(exp - 127 - (SIG_W - 1)), or a fixed special word.
   typedef struct packed {
      logic spec;
      logic [31:0] spec_word;
      logic sign;
      logic signed [EXP_W-1:0] exp;
      logic [SIG_W-1:0] sig;
      logic sticky;
   } fpint_type;

   // Partial remainder and quotient of the restoring divider.
   typedef struct packed {
      logic [24:0] rem;
      logic [SIG_W-1:0] quo;
   } divst_type;

   function automatic fclass_type cfr_class(logic [31:0] w);
      fclass_type c;
      if (w[30:23] == EXP_MAX) begin
         c = (w[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
      end else if (w[30:0] == 31'd0) begin
         c = CLS_ZERO;
      end else begin
         c = CLS_FINITE;
      end
      return c;
   endfunction

   // Subnormals get no hidden bit and the exponent of the smallest normal.
   function automatic upk_type cfr_unpack(logic [31:0] w);
      upk_type u;
      u.sig = {(w[30:23] != 8'd0), w[22:0]};
      u.eff = (w[30:23] == 8'd0) ? 8'd1 : w[30:23];
      return u;
   endfunction

   function automatic logic [5:0] cfr_lzc48(logic [47:0] v);
      logic [5:0] lz;
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            lz = 6'(47 - i);
         end
      end
      return lz;
   endfunction

   function automatic logic [4:0] cfr_lzc24(logic [23:0] v);
      logic [4:0] lz;
      lz = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            lz = 5'(23 - i);
         end
      end
      return lz;
   endfunction

   // Shift a value below the normal range right, folding lost bits into sticky.
   function automatic fpint_type cfr_denorm(fpint_type x);
      fpint_type r;
      logic [EXP_W-1:0] amt;
      logic [SIG_W-1:0] lost;
      r = x;
      amt = EXP_W'(11'sd1 - x.exp);
      lost = '0;
      if (x.exp < 11'sd1) begin
         if (amt >= EXP_W'(SIG_W)) begin
            r.sig = '0;
            r.sticky = x.sticky | (|x.sig);
         end else begin
            lost = x.sig & ~({SIG_W{1'b1}} << amt[SH_W-1:0]);
            r.sig = x.sig >> amt[SH_W-1:0];
            r.sticky = x.sticky | (|lost);
         end
         r.exp = '0;
      end
      return r;
   endfunction

   // Round to nearest-even and pack; a carry out of the fraction bumps the exponent.
   function automatic logic [31:0] cfr_round(fpint_type x);
      logic [7:0] ef;
      logic [22:0] frac;
      logic guard;
      logic st;
      logic up;
      logic [30:0] mag;
      logic [31:0] res;
      ef = x.sig[SIG_W-1] ? x.exp[7:0] : 8'd0;
      frac = x.sig[SIG_W-2 -: 23];
      guard = x.sig[SIG_W-25];
      st = (|x.sig[SIG_W-26:0]) | x.sticky;
      up = guard & (st | frac[0]);
      mag = {ef, frac} + 31'(up);
      if (x.spec) begin
         res = x.spec_word;
      end else if (x.exp > 11'sd254) begin
         res = {x.sign, POS_INF[30:0]};
      end else begin
         res = {x.sign, mag};
      end
      return res;
   endfunction

   // Several steps of restoring division.
   function automatic divst_type cfr_div_steps(divst_type x, logic [23:0] d);
      divst_type r;
      r = x;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         if (r.rem >= {1'b0, d}) begin
            r.rem = r.rem - {1'b0, d};
            r.quo = {r.quo[SIG_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[SIG_W-2:0], 1'b0};
         end
         r.rem = {r.rem[23:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/complex_float_reciprocal_core.sv -----
`timescale 1ns / 1ps

// Complex reciprocal in IEEE-754 single precision: for a + bi it returns
// a/(a*a + b*b) and -b/(a*a + b*b), each operation rounded to nearest-even,
// subnormals supported, every NaN result given as 0x7FC00000. The datapath is
// a 21-register pipeline (four squaring stages, three adder stages, thirteen
// divider stages and the output register), and one item is taken every cycle
// while the result side keeps up. The divider, which resolves three quotient
// bits per stage, sets the depth. A result waiting at a stalled output holds
// the pipeline only when the next result is also ready behind it.
module complex_float_reciprocal_core import cfr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   logic pipe_en;
   logic mul_valid, add_valid, div_valid, div_last;
   req_type mul_item, add_item;
   logic [1:0][31:0] mul_sq;
   logic [31:0] add_sum;
   logic [1:0][31:0] div_num, div_q;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   // The whole pipeline advances unless a finished item is blocked behind the output.
   assign pipe_en = !(div_valid && rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;

   cfr_fmul u_mul (
      .clock(clock),
      .reset(reset),
      .en(pipe_en),
      .in_valid(req_valid),
      .in_item(req_data),
      .out_valid(mul_valid),
      .out_item(mul_item),
      .out_sq(mul_sq)
   );

   cfr_fadd u_add (
      .clock(clock),
      .reset(reset),
      .en(pipe_en),
      .in_valid(mul_valid),
      .in_item(mul_item),
      .in_x(mul_sq[0]),
      .in_y(mul_sq[1]),
      .out_valid(add_valid),
      .out_item(add_item),
      .out_sum(add_sum)
   );

   // The imaginary numerator is the negated imaginary part.
   assign div_num = {{~add_item.in_im[31], add_item.in_im[30:0]}, add_item.in_re};

   cfr_fdiv u_div (
      .clock(clock),
      .reset(reset),
      .en(pipe_en),
      .in_valid(add_valid),
      .in_last(add_item.in_last),
      .in_den(add_sum),
      .in_num(div_num),
      .out_valid(div_valid),
      .out_last(div_last),
      .out_q(div_q)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff.out_re <= div_q[0];
         rsp_data_ff.out_im <= div_q[1];
         rsp_data_ff.out_last <= div_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The input side is held back only by a blocked output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked output");

   // A finished item held in the pipeline stays there.
   a_held_item: assert property (@(posedge clock) disable iff (reset)
      (div_valid && !pipe_en) |=> div_valid)
      else $error("held result lost");

   // NaN results are always the canonical quiet NaN.
   a_nan_re: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_re[30:23] == 8'hFF) && (rsp_data.out_re[22:0] != 23'd0))
      |-> (rsp_data.out_re == CANON_NAN))
      else $error("non-canonical NaN in real result");

   a_nan_im: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_im[30:23] == 8'hFF) && (rsp_data.out_im[22:0] != 23'd0))
      |-> (rsp_data.out_im == CANON_NAN))
      else $error("non-canonical NaN in imaginary result");

endmodule

// ----- hw/rtl/cfr_fmul.sv -----
`timescale 1ns / 1ps

// Two squaring lanes: lane 0 squares the real part, lane 1 the imaginary part.
module cfr_fmul import cfr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input req_type in_item,
   output logic out_valid,
   output req_type out_item,
   output logic [1:0][31:0] out_sq
);

   typedef struct packed {
      logic spec;
      logic [31:0] spec_word;
      logic signed [EXP_W-1:0] exp;
      logic [47:0] prod;
   } mprod_type;

   logic [1:0][31:0] opw;
   upk_type [1:0] up;
   fclass_type cls [2];
   mprod_type [1:0] s1_in, s1_ff;
   logic [1:0][5:0] lz;
   logic [1:0][47:0] norm;
   fpint_type [1:0] s2_in, s2_ff, s3_in, s3_ff;
   logic [1:0][31:0] s4_in, s4_ff;
   logic [3:0] vld_ff;
   req_type item_ff [4];

   assign opw = {in_item.in_im, in_item.in_re};

   // Stage 1: classify and form the exact product of the significands.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         up[k] = cfr_unpack(opw[k]);
         cls[k] = cfr_class(opw[k]);
         s1_in[k].spec = (cls[k] != CLS_FINITE);
         unique case (cls[k])
            CLS_NAN: s1_in[k].spec_word = CANON_NAN;
            CLS_INF: s1_in[k].spec_word = POS_INF;
            default: s1_in[k].spec_word = POS_ZERO;
         endcase
         s1_in[k].exp = $signed({2'b00, up[k].eff, 1'b0}) - 11'sd126;
         s1_in[k].prod = up[k].sig * up[k].sig;
      end
   end

   // Stage 2: normalize the product and compress it to the rounding width.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         lz[k] = cfr_lzc48(s1_ff[k].prod);
         norm[k] = s1_ff[k].prod << lz[k];
         s2_in[k].spec = s1_ff[k].spec;
         s2_in[k].spec_word = s1_ff[k].spec_word;
         s2_in[k].sign = 1'b0;
         s2_in[k].exp = s1_ff[k].exp - $signed({5'b00000, lz[k]});
         s2_in[k].sig = norm[k][47 -: SIG_W];
         s2_in[k].sticky = |norm[k][47-SIG_W:0];
      end
   end

   // Stages 3 and 4: denormalize where needed, then round.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         s3_in[k] = cfr_denorm(s2_ff[k]);
         s4_in[k] = cfr_round(s3_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         item_ff[0] <= in_item;
         for (int j = 1; j < 4; j++) begin
            item_ff[j] <= item_ff[j-1];
         end
      end
   end

   assign out_valid = vld_ff[3];
   assign out_item = item_ff[3];
   assign out_sq = s4_ff;

endmodule

// ----- hw/rtl/cfr_fadd.sv -----
`timescale 1ns / 1ps

// Adds the two squares. Both operands are non-negative, so only magnitudes add.
module cfr_fadd import cfr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input req_type in_item,
   input logic [31:0] in_x,
   input logic [31:0] in_y,
   output logic out_valid,
   output req_type out_item,
   output logic [31:0] out_sum
);

   typedef struct packed {
      logic spec;
      logic [31:0] spec_word;
      logic [31:0] big;
      logic [31:0] lesser;
   } aswap_type;

   typedef struct packed {
      logic spec;
      logic [31:0] spec_word;
      logic [7:0] eff;
      logic [SIG_W:0] sum;
      logic sticky;
   } asum_type;

   fclass_type cx, cy;
   aswap_type a1_in, a1_ff;
   asum_type a2_in, a2_ff;
   upk_type ux, uy;
   logic [7:0] diff;
   logic [SIG_W-1:0] ywide, yshift;
   logic ylost;
   fpint_type a3_pre;
   logic [31:0] a3_in, a3_ff;
   logic [2:0] vld_ff;
   req_type item_ff [3];

   // Stage 1: special cases and operand ordering by magnitude.
   always_comb begin
      cx = cfr_class(in_x);
      cy = cfr_class(in_y);
      a1_in.spec = (cx == CLS_NAN) || (cy == CLS_NAN) || (cx == CLS_INF) || (cy == CLS_INF);
      a1_in.spec_word = ((cx == CLS_NAN) || (cy == CLS_NAN)) ? CANON_NAN : POS_INF;
      if (in_y[30:0] > in_x[30:0]) begin
         a1_in.big = in_y;
         a1_in.lesser = in_x;
      end else begin
         a1_in.big = in_x;
         a1_in.lesser = in_y;
      end
   end

   // Stage 2: align the smaller operand and add.
   always_comb begin
      ux = cfr_unpack(a1_ff.big);
      uy = cfr_unpack(a1_ff.lesser);
      diff = ux.eff - uy.eff;
      ywide = {uy.sig, {(SIG_W-24){1'b0}}};
      if (diff >= 8'(SIG_W)) begin
         yshift = '0;
         ylost = |uy.sig;
      end else begin
         yshift = ywide >> diff[SH_W-1:0];
         ylost = |(ywide & ~({SIG_W{1'b1}} << diff[SH_W-1:0]));
      end
      a2_in.spec = a1_ff.spec;
      a2_in.spec_word = a1_ff.spec_word;
      a2_in.eff = ux.eff;
      a2_in.sum = {1'b0, ux.sig, {(SIG_W-24){1'b0}}} + {1'b0, yshift};
      a2_in.sticky = ylost;
   end

   // Stage 3: fold a carry out of the sum, then round.
   always_comb begin
      a3_pre.spec = a2_ff.spec;
      a3_pre.spec_word = a2_ff.spec_word;
      a3_pre.sign = 1'b0;
      if (a2_ff.sum[SIG_W]) begin
         a3_pre.sig = a2_ff.sum[SIG_W:1];
         a3_pre.sticky = a2_ff.sticky | a2_ff.sum[0];
         a3_pre.exp = $signed({3'b000, a2_ff.eff}) + 11'sd1;
      end else begin
         a3_pre.sig = a2_ff.sum[SIG_W-1:0];
         a3_pre.sticky = a2_ff.sticky;
         a3_pre.exp = $signed({3'b000, a2_ff.eff});
      end
      a3_in = cfr_round(a3_pre);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         a3_ff <= a3_in;
         item_ff[0] <= in_item;
         for (int j = 1; j < 3; j++) begin
            item_ff[j] <= item_ff[j-1];
         end
      end
   end

   assign out_valid = vld_ff[2];
   assign out_item = item_ff[2];
   assign out_sum = a3_ff;

endmodule

// ----- hw/rtl/cfr_fdiv.sv -----
`timescale 1ns / 1ps

// Two division lanes sharing one divisor; lane 0 gives the real, lane 1 the imaginary result.
module cfr_fdiv import cfr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input logic in_last,
   input logic [31:0] in_den,
   input logic [1:0][31:0] in_num,
   output logic out_valid,
   output logic out_last,
   output logic [1:0][31:0] out_q
);

   typedef struct packed {
      logic spec;
      logic [31:0] spec_word;
      logic sign;
      logic signed [EXP_W-1:0] exp;
      logic [23:0] nn;
   } dprep_type;

   typedef struct packed {
      logic spec;
      logic [31:0] spec_word;
      logic sign;
      logic signed [EXP_W-1:0] exp;
      divst_type st;
   } dlane_type;

   localparam int NPIPE = DIV_ITER_STAGES + 1;

   fclass_type cd;
   fclass_type cn [2];
   upk_type ud;
   upk_type [1:0] un;
   logic [4:0] lzd;
   logic [1:0][4:0] lzn;
   logic signed [EXP_W-1:0] ed;
   logic signed [EXP_W-1:0] en_exp [2];
   logic [31:0] sgn_inf [2];
   logic [31:0] sgn_zero [2];
   dprep_type [1:0] p1_in, p1_ff;
   logic [23:0] p1_dn_in, p1_dn_ff;
   logic p1_vld_ff, p1_last_ff;
   dlane_type [1:0] pipe_in [NPIPE];
   dlane_type [1:0] pipe_ff [NPIPE];
   logic [23:0] dn_ff [DIV_ITER_STAGES];
   logic [NPIPE-1:0] vld_ff, last_ff;
   fpint_type [1:0] quo_fp, sub_in, sub_ff;
   logic sub_vld_ff, sub_last_ff;
   logic [1:0][31:0] q_in, q_ff;
   logic q_vld_ff, q_last_ff;

   // Stage 1: special cases, and normalization of subnormal operands.
   always_comb begin
      cd = cfr_class(in_den);
      ud = cfr_unpack(in_den);
      lzd = cfr_lzc24(ud.sig);
      p1_dn_in = ud.sig << lzd;
      ed = $signed({3'b000, ud.eff}) - $signed({6'b000000, lzd});
      for (int k = 0; k < 2; k++) begin
         cn[k] = cfr_class(in_num[k]);
         un[k] = cfr_unpack(in_num[k]);
         lzn[k] = cfr_lzc24(un[k].sig);
         en_exp[k] = $signed({3'b000, un[k].eff}) - $signed({6'b000000, lzn[k]});
         p1_in[k].sign = in_num[k][31] ^ in_den[31];
         sgn_inf[k] = {p1_in[k].sign, POS_INF[30:0]};
         sgn_zero[k] = {p1_in[k].sign, POS_ZERO[30:0]};
         p1_in[k].nn = un[k].sig << lzn[k];
         p1_in[k].exp = en_exp[k] - ed + 11'sd127;
         p1_in[k].spec = 1'b1;
         priority if ((cd == CLS_NAN) || (cn[k] == CLS_NAN)) begin
            p1_in[k].spec_word = CANON_NAN;
         end else if (((cn[k] == CLS_INF) && (cd == CLS_INF)) ||
                      ((cn[k] == CLS_ZERO) && (cd == CLS_ZERO))) begin
            p1_in[k].spec_word = CANON_NAN;
         end else if ((cn[k] == CLS_INF) || (cd == CLS_ZERO)) begin
            p1_in[k].spec_word = sgn_inf[k];
         end else if ((cn[k] == CLS_ZERO) || (cd == CLS_INF)) begin
            p1_in[k].spec_word = sgn_zero[k];
         end else begin
            p1_in[k].spec = 1'b0;
            p1_in[k].spec_word = POS_ZERO;
         end
      end
   end

   // Stage 2 brings the numerator to at least the divisor; later stages each
   // resolve a few quotient bits.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         pipe_in[0][k].spec = p1_ff[k].spec;
         pipe_in[0][k].spec_word = p1_ff[k].spec_word;
         pipe_in[0][k].sign = p1_ff[k].sign;
         pipe_in[0][k].st.quo = '0;
         if (p1_ff[k].nn < p1_dn_ff) begin
            pipe_in[0][k].st.rem = {p1_ff[k].nn, 1'b0};
            pipe_in[0][k].exp = p1_ff[k].exp - 11'sd1;
         end else begin
            pipe_in[0][k].st.rem = {1'b0, p1_ff[k].nn};
            pipe_in[0][k].exp = p1_ff[k].exp;
         end
      end
      for (int j = 0; j < DIV_ITER_STAGES; j++) begin
         for (int k = 0; k < 2; k++) begin
            pipe_in[j+1][k] = pipe_ff[j][k];
            pipe_in[j+1][k].st = cfr_div_steps(pipe_ff[j][k].st, dn_ff[j]);
         end
      end
   end

   // Final stages: a non-zero remainder is sticky, then denormalize and round.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         quo_fp[k].spec = pipe_ff[NPIPE-1][k].spec;
         quo_fp[k].spec_word = pipe_ff[NPIPE-1][k].spec_word;
         quo_fp[k].sign = pipe_ff[NPIPE-1][k].sign;
         quo_fp[k].exp = pipe_ff[NPIPE-1][k].exp;
         quo_fp[k].sig = pipe_ff[NPIPE-1][k].st.quo;
         quo_fp[k].sticky = |pipe_ff[NPIPE-1][k].st.rem;
         sub_in[k] = cfr_denorm(quo_fp[k]);
         q_in[k] = cfr_round(sub_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         vld_ff <= '0;
         sub_vld_ff <= 1'b0;
         q_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= in_valid;
         vld_ff <= {vld_ff[NPIPE-2:0], p1_vld_ff};
         sub_vld_ff <= vld_ff[NPIPE-1];
         q_vld_ff <= sub_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p1_dn_ff <= p1_dn_in;
         p1_last_ff <= in_last;
         last_ff <= {last_ff[NPIPE-2:0], p1_last_ff};
         dn_ff[0] <= p1_dn_ff;
         for (int j = 1; j < DIV_ITER_STAGES; j++) begin
            dn_ff[j] <= dn_ff[j-1];
         end
         for (int j = 0; j < NPIPE; j++) begin
            pipe_ff[j] <= pipe_in[j];
         end
         sub_ff <= sub_in;
         sub_last_ff <= last_ff[NPIPE-1];
         q_ff <= q_in;
         q_last_ff <= sub_last_ff;
      end
   end

   assign out_valid = q_vld_ff;
   assign out_last = q_last_ff;
   assign out_q = q_ff;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import cfr_pkg::*;

   // Unpacked single-precision operand: value = mag * 2^pow.
   typedef struct {
      logic sgn;
      logic is_nan;
      logic is_inf;
      logic is_zero;
      logic [23:0] mag;
      int pow;
   } fp_parts_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;

   rsp_type recip_pending[$];
   int mismatches;
   logic gaps_on;

   complex_float_reciprocal_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Split a word into class, sign and an integer significand with its scale.
   function automatic fp_parts_type fp_split(logic [31:0] w);
      fp_parts_type p;
      p.sgn = w[31];
      p.is_nan = (w[30:23] == 8'hFF) && (w[22:0] != 0);
      p.is_inf = (w[30:23] == 8'hFF) && (w[22:0] == 0);
      p.is_zero = (w[30:0] == 0);
      if (w[30:23] == 0) begin
         p.mag = {1'b0, w[22:0]};
         p.pow = -149;
      end else begin
         p.mag = {1'b1, w[22:0]};
         p.pow = int'(w[30:23]) - 150;
      end
      return p;
   endfunction

   // Round m * 2^e (plus a sticky tail) to nearest-even and pack it.
   function automatic logic [31:0] fp_round(logic sgn, logic [99:0] m, int e, logic st);
      int msb;
      int lsb;
      int sh;
      int bexp;
      logic [99:0] q;
      logic g;
      logic rest;
      if (m == 0) return {sgn, 31'd0};
      msb = 0;
      for (int i = 0; i < 100; i++) if (m[i]) msb = i;
      lsb = msb + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      if (sh >= 100) begin
         q = 0;
         g = 0;
         rest = 1'b1;
      end else if (sh > 0) begin
         q = m >> sh;
         g = m[sh-1];
         rest = st | (|(m & ~({100{1'b1}} << (sh - 1))));
      end else begin
         q = m << (-sh);
         g = 0;
         rest = st;
      end
      q = q + (g & (rest | q[0]));
      if (q[24]) begin
         q = q >> 1;
         lsb++;
      end
      if (!q[23]) return {sgn, 8'd0, q[22:0]};
      bexp = lsb + 150;
      if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, bexp[7:0], q[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] x, logic [31:0] y);
      fp_parts_type a;
      fp_parts_type b;
      logic s;
      a = fp_split(x);
      b = fp_split(y);
      s = a.sgn ^ b.sgn;
      if (a.is_nan || b.is_nan || (a.is_inf && b.is_zero) || (a.is_zero && b.is_inf))
         return CANON_NAN;
      if (a.is_inf || b.is_inf) return {s, 8'hFF, 23'd0};
      if (a.is_zero || b.is_zero) return {s, 31'd0};
      return fp_round(s, 100'(a.mag) * 100'(b.mag), a.pow + b.pow, 1'b0);
   endfunction

   // Sum of two squares: both operands are non-negative, so no cancellation.
   function automatic logic [31:0] fp_add_pos(logic [31:0] x, logic [31:0] y);
      fp_parts_type a;
      fp_parts_type b;
      fp_parts_type t;
      int d;
      a = fp_split(x);
      b = fp_split(y);
      if (a.is_nan || b.is_nan) return CANON_NAN;
      if (a.is_inf || b.is_inf) return POS_INF;
      if (a.is_zero) return y;
      if (b.is_zero) return x;
      if (a.pow < b.pow) begin
         t = a;
         a = b;
         b = t;
      end
      d = a.pow - b.pow;
      // A far smaller addend only affects the sticky bit.
      if (d > 60)
         return fp_round(1'b0, 100'(a.mag) << 60, a.pow - 60, 1'b1);
      return fp_round(1'b0, (100'(a.mag) << d) + 100'(b.mag), b.pow, 1'b0);
   endfunction

   function automatic logic [31:0] fp_div(logic [31:0] x, logic [31:0] y);
      fp_parts_type a;
      fp_parts_type b;
      logic s;
      logic [99:0] num;
      logic [99:0] den;
      a = fp_split(x);
      b = fp_split(y);
      s = a.sgn ^ b.sgn;
      if (a.is_nan || b.is_nan || (a.is_inf && b.is_inf) || (a.is_zero && b.is_zero))
         return CANON_NAN;
      if (a.is_inf || b.is_zero) return {s, 8'hFF, 23'd0};
      if (a.is_zero || b.is_inf) return {s, 31'd0};
      // Normalize both significands so the quotient has plenty of bits.
      while (!a.mag[23]) begin
         a.mag = a.mag << 1;
         a.pow--;
      end
      while (!b.mag[23]) begin
         b.mag = b.mag << 1;
         b.pow--;
      end
      num = 100'(a.mag) << 50;
      den = 100'(b.mag);
      return fp_round(s, num / den, a.pow - b.pow - 50, (num % den) != 0);
   endfunction

   function automatic rsp_type recip_of(req_type r);
      rsp_type o;
      logic [31:0] mag2;
      mag2 = fp_add_pos(fp_mul(r.in_re, r.in_re), fp_mul(r.in_im, r.in_im));
      o.out_re = fp_div(r.in_re, mag2);
      o.out_im = fp_div({~r.in_im[31], r.in_im[30:0]}, mag2);
      o.out_last = r.in_last;
      return o;
   endfunction

   // Random float word, weighted toward special values and extreme exponents.
   function automatic logic [31:0] rand_float();
      logic [31:0] w;
      int pick;
      w = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) w[30:0] = 31'd0;
      else if (pick < 13) w[30:0] = {8'hFF, 23'd0};
      else if (pick < 18) w[30:23] = 8'hFF;
      else if (pick < 28) w[30:23] = 8'd0;
      else if (pick < 40) w[30:23] = 8'($urandom_range(190, 254));
      else if (pick < 52) w[30:23] = 8'($urandom_range(1, 64));
      else if (pick < 80) w[30:23] = 8'($urandom_range(100, 154));
      return w;
   endfunction

   // Drive one item and hold it until it is taken.
   task automatic send_item(logic [31:0] re, logic [31:0] im, logic last);
      req_type r;
      @(negedge clock);
      if (gaps_on && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      r.in_re = re;
      r.in_im = im;
      r.in_last = last;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      recip_pending.push_back(recip_of(r));
   endtask

   // Result side stalls at random while gaps are enabled.
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 18);
   end

   // Compare each result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (recip_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %h", rsp_data);
         end else begin
            want = recip_pending.pop_front();
            if (rsp_data.out_re !== want.out_re || rsp_data.out_im !== want.out_im ||
                rsp_data.out_last !== want.out_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp re %h im %h last %b, got re %h im %h last %b",
                           want.out_re, want.out_im, want.out_last,
                           rsp_data.out_re, rsp_data.out_im, rsp_data.out_last);
            end
         end
      end
   end

   task automatic test_directed();
      logic [31:0] vals[12];
      vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
               32'h7F7F_FFFF, 32'h3F80_0000, 32'h0080_0000, 32'hBF80_0000};
      for (int i = 0; i < 12; i++) send_item(vals[i], vals[(i * 5 + 3) % 12], i[0]);
      // Squares that overflow, underflow, and a tie-heavy mid range value.
      send_item(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
      send_item(32'h2000_0000, 32'h1F00_0000, 1'b0);
      send_item(32'h0000_0000, 32'h0000_0001, 1'b1);
      send_item(32'h5F80_0000, 32'h0000_0000, 1'b0);
      send_item(32'h3FB5_04F3, 32'hBFB5_04F3, 1'b1);
      send_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_item(32'h1F80_0000, 32'h7F80_0000, 1'b1);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         // A long stretch in the middle runs with no idling on either side.
         gaps_on = !(i >= count / 3 && i < count / 2);
         send_item(rand_float(), rand_float(), $urandom_range(1));
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      mismatches = 0;
      gaps_on = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1800);
      @(negedge clock);
      req_valid <= 1'b0;
      while (recip_pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Run time guard.
   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
